// ===== hw/rtl/hclm_pkg.sv =====
// Shared types, constants and helper functions of the Hough cell layer matcher.
package hclm_pkg;

	localparam int LAYERS = 6;
	localparam int MIN_LAYERS = 5;
	localparam logic [10:0] COUNT_MAX = 11'd2047;
	localparam logic [3:0] CLU_LAST_READ = 4'd8;
	localparam logic [3:0] CLU_LAST_STEP = 4'd10;

	localparam logic [2:0] FN_LOAD = 3'd0;
	localparam logic [2:0] FN_CLEAR = 3'd1;
	localparam logic [2:0] FN_HIT = 3'd2;
	localparam logic [2:0] FN_CLUSTER = 3'd3;
	localparam logic [2:0] FN_QUERY = 3'd4;

	localparam logic REG_ACTIVE_A = 1'b0;
	localparam logic REG_ACTIVE_B = 1'b1;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CLEAR,
		OP_HIT,
		OP_CLUSTER,
		OP_QUERY
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_HIT,
		ST_DRAIN,
		ST_CLU,
		ST_QRY,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic start;
		logic load;
		op_t  op;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic last_cell;
		logic step_last;
		logic out_free;
		logic empty;
	} status_t;

	typedef struct packed {
		logic signed [1:0] da;
		logic signed [1:0] db;
		logic              strict;
	} nb_off_t;

	function automatic logic [2:0] layer_count(input logic [5:0] m);
		logic [2:0] n;
		n = '0;
		for (int i = 0; i < LAYERS; i++) begin
			n = n + 3'(m[i]);
		end
		return n;
	endfunction

	// Position of a possible centre relative to the cell under test, and whether
	// the cell falls only on a strictly smaller layer count.
	function automatic nb_off_t nb_offset(input logic [3:0] k);
		nb_off_t o;
		case (k)
			4'd1: o = '{da: -2'sd1, db: -2'sd1, strict: 1'b0};
			4'd2: o = '{da: -2'sd1, db: 2'sd0, strict: 1'b0};
			4'd3: o = '{da: -2'sd1, db: 2'sd1, strict: 1'b0};
			4'd4: o = '{da: 2'sd0, db: 2'sd1, strict: 1'b0};
			4'd5: o = '{da: 2'sd1, db: 2'sd1, strict: 1'b1};
			4'd6: o = '{da: 2'sd1, db: 2'sd0, strict: 1'b1};
			4'd7: o = '{da: 2'sd1, db: -2'sd1, strict: 1'b1};
			4'd8: o = '{da: 2'sd0, db: -2'sd1, strict: 1'b1};
			default: o = '{da: 2'sd0, db: 2'sd0, strict: 1'b0};
		endcase
		return o;
	endfunction

endpackage

// ===== hw/rtl/hclm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hclm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/hclm_ctrl.sv =====
// Controller state machine of the Hough cell layer matcher.
module hclm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          func,
	input  logic [2:0]          layer,
	input  hclm_pkg::status_t   status,
	output hclm_pkg::cmd_t      cmd
);

	hclm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hclm_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		cmd = '{start: 1'b0, load: 1'b0, op: hclm_pkg::OP_NONE, emit: 1'b0};
		case (state_q)
			hclm_pkg::ST_INIT: begin
				cmd.op = hclm_pkg::OP_CLEAR;
				if (status.last_cell) begin
					state_d = hclm_pkg::ST_IDLE;
				end
			end
			hclm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					case (func)
						hclm_pkg::FN_LOAD: cmd.load = 1'b1;
						hclm_pkg::FN_CLEAR: state_d = hclm_pkg::ST_CLEAR;
						hclm_pkg::FN_HIT: begin
							if (32'(layer) < hclm_pkg::LAYERS && !status.empty) begin
								state_d = hclm_pkg::ST_HIT;
							end
						end
						hclm_pkg::FN_CLUSTER: begin
							state_d = status.empty ? hclm_pkg::ST_RESULT : hclm_pkg::ST_CLU;
						end
						hclm_pkg::FN_QUERY: state_d = hclm_pkg::ST_QRY;
						default: state_d = hclm_pkg::ST_IDLE;
					endcase
				end
			end
			hclm_pkg::ST_CLEAR: begin
				cmd.op = hclm_pkg::OP_CLEAR;
				if (status.last_cell) begin
					state_d = hclm_pkg::ST_IDLE;
				end
			end
			hclm_pkg::ST_HIT: begin
				cmd.op = hclm_pkg::OP_HIT;
				if (status.last_cell) begin
					state_d = hclm_pkg::ST_DRAIN;
				end
			end
			hclm_pkg::ST_DRAIN: state_d = hclm_pkg::ST_IDLE;
			hclm_pkg::ST_CLU: begin
				cmd.op = hclm_pkg::OP_CLUSTER;
				if (status.last_cell && status.step_last) begin
					state_d = hclm_pkg::ST_RESULT;
				end
			end
			hclm_pkg::ST_QRY: begin
				cmd.op = hclm_pkg::OP_QUERY;
				state_d = hclm_pkg::ST_RESULT;
			end
			hclm_pkg::ST_RESULT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = hclm_pkg::ST_IDLE;
				end
			end
			default: state_d = hclm_pkg::ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/hclm_dp.sv =====
// Datapath of the Hough cell layer matcher: stores, cell iterator, compare and counts.
module hclm_dp #(
	parameter int GRID_A = 32,
	parameter int GRID_B = 32,
	parameter int POSITION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hclm_pkg::cmd_t                  cmd,
	output hclm_pkg::status_t               status,
	input  logic                            cfg_valid,
	input  logic                            cfg_index,
	input  logic [5:0]                      cfg_data,
	input  logic [2:0]                      func,
	input  logic [4:0]                      cell_a,
	input  logic [4:0]                      cell_b,
	input  logic [2:0]                      layer,
	input  logic signed [POSITION_BITS-1:0] window_low,
	input  logic signed [POSITION_BITS-1:0] window_high,
	input  logic signed [POSITION_BITS-1:0] hit_position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            result_kind,
	output logic [10:0]                     count_six,
	output logic [10:0]                     count_five,
	output logic [2:0]                      layers_hit,
	output logic                            cell_suppressed
);

	localparam int NCELLS = GRID_A * GRID_B;
	localparam int CW = $clog2(NCELLS);
	localparam int WAW = $clog2(NCELLS * hclm_pkg::LAYERS);
	localparam int AW = $clog2(GRID_A);
	localparam int BW = $clog2(GRID_B);
	localparam int NAW = $clog2(GRID_A + 1);
	localparam int NBW = $clog2(GRID_B + 1);
	localparam int SAW = NAW + 1;
	localparam int SBW = NBW + 1;
	localparam int PB = POSITION_BITS;

	logic [5:0] act_a_q, act_b_q;
	logic [NAW-1:0] eff_a, lim_a;
	logic [NBW-1:0] eff_b, lim_b;
	logic [AW-1:0] it_a_q;
	logic [BW-1:0] it_b_q;
	logic [3:0] k_q;
	logic last_a, last_b, adv;
	logic [CW-1:0] cell_addr;

	logic [2:0] func_q, layer_q;
	logic [4:0] qa_q, qb_q;
	logic signed [PB-1:0] pos_q;

	logic c_we, c_re, w_we, w_re;
	logic [CW-1:0] c_waddr, c_raddr;
	logic [6:0] c_wdata, c_rdata;
	logic [WAW-1:0] w_waddr, w_raddr;
	logic [2*PB-1:0] w_rdata;

	hclm_pkg::nb_off_t off;
	logic signed [SAW-1:0] ca, na_s;
	logic signed [SBW-1:0] cb, nb_s;
	logic nb_ok;
	logic [CW-1:0] nb_addr;

	logic hit_vld_s1;
	logic [CW-1:0] hit_addr_s1;
	logic clu_vld_s1, nb_ok_s1, strict_s1;
	logic [3:0] k_s1;

	logic [2:0] nself_q, n_rd;
	logic [5:0] mself_q;
	logic flag_q;
	logic [10:0] c6_q, c5_q;
	logic signed [PB-1:0] lo, hi;
	logic match, clu_write, q_in_grid, load_ok;
	logic [5:0] hit_bit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_a_q <= 6'd32;
			act_b_q <= 6'd32;
		end else if (cfg_valid) begin
			case (cfg_index)
				hclm_pkg::REG_ACTIVE_A: act_a_q <= cfg_data;
				hclm_pkg::REG_ACTIVE_B: act_b_q <= cfg_data;
				default: act_a_q <= act_a_q;
			endcase
		end
	end

	assign eff_a = (32'(act_a_q) > GRID_A) ? NAW'(GRID_A) : NAW'(act_a_q);
	assign eff_b = (32'(act_b_q) > GRID_B) ? NBW'(GRID_B) : NBW'(act_b_q);
	assign lim_a = (cmd.op == hclm_pkg::OP_CLEAR) ? NAW'(GRID_A) : eff_a;
	assign lim_b = (cmd.op == hclm_pkg::OP_CLEAR) ? NBW'(GRID_B) : eff_b;

	assign last_a = (NAW'(it_a_q) + NAW'(1)) == lim_a;
	assign last_b = (NBW'(it_b_q) + NBW'(1)) == lim_b;
	assign adv = (cmd.op == hclm_pkg::OP_CLEAR) || (cmd.op == hclm_pkg::OP_HIT)
		|| (cmd.op == hclm_pkg::OP_CLUSTER && k_q == hclm_pkg::CLU_LAST_STEP);
	assign cell_addr = CW'(32'(it_a_q) * GRID_B + 32'(it_b_q));

	always_comb begin
		status.last_cell = last_a && last_b;
		status.step_last = (k_q == hclm_pkg::CLU_LAST_STEP);
		status.out_free = !out_valid || out_ready;
		status.empty = (eff_a == '0) || (eff_b == '0);
	end

	// Cell iterator and cluster step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_a_q <= '0;
			it_b_q <= '0;
			k_q <= '0;
		end else if (cmd.start) begin
			it_a_q <= '0;
			it_b_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.op == hclm_pkg::OP_CLUSTER) begin
				k_q <= (k_q == hclm_pkg::CLU_LAST_STEP) ? 4'd0 : k_q + 4'd1;
			end
			if (adv) begin
				if (last_b) begin
					it_b_q <= '0;
					it_a_q <= last_a ? '0 : it_a_q + AW'(1);
				end else begin
					it_b_q <= it_b_q + BW'(1);
				end
			end
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= func;
			qa_q <= cell_a;
			qb_q <= cell_b;
			layer_q <= layer;
			pos_q <= hit_position;
		end
	end

	// Neighbouring centre for the current cluster step.
	always_comb begin
		off = hclm_pkg::nb_offset(k_q);
		na_s = $signed({1'b0, eff_a});
		nb_s = $signed({1'b0, eff_b});
		ca = $signed({1'b0, NAW'(it_a_q)}) + off.da;
		cb = $signed({1'b0, NBW'(it_b_q)}) + off.db;
		nb_ok = (ca > 0) && (ca < na_s - 1) && (cb > 0) && (cb < nb_s - 1);
		nb_addr = CW'(32'(ca[AW-1:0]) * GRID_B + 32'(cb[BW-1:0]));
	end

	assign q_in_grid = (32'(qa_q) < GRID_A) && (32'(qb_q) < GRID_B);
	assign load_ok = cmd.load && (32'(cell_a) < GRID_A) && (32'(cell_b) < GRID_B)
		&& (32'(layer) < hclm_pkg::LAYERS);

	// Window store.
	assign w_we = load_ok;
	assign w_waddr = WAW'((32'(cell_a) * GRID_B + 32'(cell_b)) * hclm_pkg::LAYERS
		+ 32'(layer));
	assign w_re = (cmd.op == hclm_pkg::OP_HIT);
	assign w_raddr = WAW'(32'(cell_addr) * hclm_pkg::LAYERS + 32'(layer_q));

	hclm_ram #(
		.WIDTH(2 * PB),
		.DEPTH(NCELLS * hclm_pkg::LAYERS)
	) u_win_ram (
		.clk(clk),
		.we(w_we),
		.waddr(w_waddr),
		.wdata({window_high, window_low}),
		.re(w_re),
		.raddr(w_raddr),
		.rdata(w_rdata)
	);

	// Cell store: suppressed flag above the six layer bits.
	assign c_re = (cmd.op == hclm_pkg::OP_HIT) || (cmd.op == hclm_pkg::OP_QUERY)
		|| (cmd.op == hclm_pkg::OP_CLUSTER && k_q <= hclm_pkg::CLU_LAST_READ);

	always_comb begin
		case (cmd.op)
			hclm_pkg::OP_CLUSTER: c_raddr = (k_q == 4'd0) ? cell_addr : nb_addr;
			hclm_pkg::OP_QUERY: c_raddr = CW'(32'(qa_q) * GRID_B + 32'(qb_q));
			default: c_raddr = cell_addr;
		endcase
	end

	assign lo = $signed(w_rdata[PB-1:0]);
	assign hi = $signed(w_rdata[2*PB-1:PB]);
	assign match = (lo <= pos_q) && (pos_q <= hi);
	assign hit_bit = 6'd1 << layer_q;
	assign clu_write = (cmd.op == hclm_pkg::OP_CLUSTER) && (k_q == hclm_pkg::CLU_LAST_STEP);

	always_comb begin
		c_we = 1'b0;
		c_waddr = cell_addr;
		c_wdata = '0;
		if (cmd.op == hclm_pkg::OP_CLEAR) begin
			c_we = 1'b1;
		end else if (hit_vld_s1) begin
			c_we = 1'b1;
			c_waddr = hit_addr_s1;
			c_wdata = {c_rdata[6], c_rdata[5:0] | (match ? hit_bit : 6'd0)};
		end else if (clu_write) begin
			c_we = 1'b1;
			c_wdata = {flag_q, mself_q};
		end
	end

	hclm_ram #(
		.WIDTH(7),
		.DEPTH(NCELLS)
	) u_cell_ram (
		.clk(clk),
		.we(c_we),
		.waddr(c_waddr),
		.wdata(c_wdata),
		.re(c_re),
		.raddr(c_raddr),
		.rdata(c_rdata)
	);

	// Read tags for the registered store outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_vld_s1 <= 1'b0;
			clu_vld_s1 <= 1'b0;
		end else begin
			hit_vld_s1 <= (cmd.op == hclm_pkg::OP_HIT);
			clu_vld_s1 <= (cmd.op == hclm_pkg::OP_CLUSTER) && (k_q <= hclm_pkg::CLU_LAST_READ);
		end
	end

	always_ff @(posedge clk) begin
		hit_addr_s1 <= cell_addr;
		k_s1 <= k_q;
		nb_ok_s1 <= nb_ok;
		strict_s1 <= off.strict;
	end

	assign n_rd = hclm_pkg::layer_count(c_rdata[5:0]);

	// Suppression decision for the cell under test, then the counts.
	always_ff @(posedge clk) begin
		if (clu_vld_s1) begin
			if (k_s1 == 4'd0) begin
				nself_q <= n_rd;
				mself_q <= c_rdata[5:0];
				flag_q <= c_rdata[6] || (32'(n_rd) < hclm_pkg::MIN_LAYERS);
			end else if (nb_ok_s1 && 32'(n_rd) >= hclm_pkg::MIN_LAYERS
				&& (strict_s1 ? (nself_q < n_rd) : (nself_q <= n_rd))) begin
				flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c6_q <= '0;
			c5_q <= '0;
		end else if (cmd.start) begin
			c6_q <= '0;
			c5_q <= '0;
		end else if (clu_write && !flag_q) begin
			if (nself_q == 3'd6 && c6_q != hclm_pkg::COUNT_MAX) begin
				c6_q <= c6_q + 11'd1;
			end
			if (nself_q == 3'd5 && c5_q != hclm_pkg::COUNT_MAX) begin
				c5_q <= c5_q + 11'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (func_q == hclm_pkg::FN_CLUSTER) begin
				result_kind <= 1'b0;
				count_six <= c6_q;
				count_five <= c5_q;
				layers_hit <= 3'd0;
				cell_suppressed <= 1'b0;
			end else begin
				result_kind <= 1'b1;
				count_six <= 11'd0;
				count_five <= 11'd0;
				layers_hit <= q_in_grid ? n_rd : 3'd0;
				cell_suppressed <= q_in_grid ? c_rdata[6] : 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/hough_cell_layer_matcher_core.sv =====
// Top level of the Hough cell layer matcher: controller, datapath and ports.
//
//   channel  handshake            payload
//   in       in_valid / in_ready  func cell_a cell_b layer window_low window_high hit_position
//   out      out_valid/out_ready  result_kind count_six count_five layers_hit cell_suppressed
//   cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// A load writes the window store as it is taken. A clear walks every cell of the grid
// and a hit every active cell, one cell a cycle through the window store. A cluster item
// makes nine reads of the single cell store read port per active cell.
// After reset the cell store is cleared before any item is taken.
// A waiting result stalls the next cluster or query item, and no item is taken behind it; cfg is always ready.
module hough_cell_layer_matcher_core #(
	parameter int GRID_A = 32,
	parameter int GRID_B = 32,
	parameter int POSITION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [2:0]                      func,
	input  logic [4:0]                      cell_a,
	input  logic [4:0]                      cell_b,
	input  logic [2:0]                      layer,
	input  logic signed [POSITION_BITS-1:0] window_low,
	input  logic signed [POSITION_BITS-1:0] window_high,
	input  logic signed [POSITION_BITS-1:0] hit_position,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            result_kind,
	output logic [10:0]                     count_six,
	output logic [10:0]                     count_five,
	output logic [2:0]                      layers_hit,
	output logic                            cell_suppressed,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [5:0]                      cfg_data
);

	hclm_pkg::cmd_t cmd;
	hclm_pkg::status_t status;

	assign cfg_ready = 1'b1;

	hclm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.layer(layer),
		.status(status),
		.cmd(cmd)
	);

	hclm_dp #(
		.GRID_A(GRID_A),
		.GRID_B(GRID_B),
		.POSITION_BITS(POSITION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.func(func),
		.cell_a(cell_a),
		.cell_b(cell_b),
		.layer(layer),
		.window_low(window_low),
		.window_high(window_high),
		.hit_position(hit_position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.count_six(count_six),
		.count_five(count_five),
		.layers_hit(layers_hit),
		.cell_suppressed(cell_suppressed)
	);

endmodule
